/* hw/rtl/sacl_pkg.sv */
// Shared constants and types for the set-associative LRU write-back cache.
// Used by the channel interfaces, the lookup unit, the top level and the checker.
`default_nettype none

package sacl_pkg;

   localparam int ADDR_W        = 32;
   localparam int COUNT_W       = 32;
   localparam int TAG_W         = 32;
   localparam int WAY_OUT_W     = 3;
   localparam int WAY_MAX_W     = 4;
   localparam int INDEX_CFG_W   = 3;
   localparam int OFFSET_CFG_W  = 4;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_SEL_BIT   = 2;

   localparam logic [INDEX_CFG_W-1:0]  INDEX_BITS_RESET  = 3'd4;
   localparam logic [OFFSET_CFG_W-1:0] OFFSET_BITS_RESET = 4'd3;

   localparam logic REG_INDEX_BITS  = 1'b0;
   localparam logic REG_OFFSET_BITS = 1'b1;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic                 hit;
      logic                 write_back;
      logic [WAY_MAX_W-1:0] way;
   } lookup_result_type;

endpackage

`default_nettype wire

/* hw/rtl/sacl_req_if.sv */
// Request channel: one access word (command and byte address).
// Depends on sacl_pkg.
`default_nettype none

interface sacl_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [sacl_pkg::ADDR_W-1:0] address;

   modport source (output valid, command, address, input ready);
   modport sink   (input valid, command, address, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sacl_rsp_if.sv */
// Response channel: hit, write-back, way and the five running counters.
// Depends on sacl_pkg.
`default_nettype none

interface sacl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic                           write_back;
   logic [sacl_pkg::WAY_OUT_W-1:0] way_used;
   logic [sacl_pkg::COUNT_W-1:0]   read_hit_count;
   logic [sacl_pkg::COUNT_W-1:0]   write_hit_count;
   logic [sacl_pkg::COUNT_W-1:0]   read_miss_count;
   logic [sacl_pkg::COUNT_W-1:0]   write_miss_count;
   logic [sacl_pkg::COUNT_W-1:0]   write_back_count;

   modport source (output valid, hit, write_back, way_used, read_hit_count, write_hit_count,
                   read_miss_count, write_miss_count, write_back_count, input ready);
   modport sink   (input valid, hit, write_back, way_used, read_hit_count, write_hit_count,
                   read_miss_count, write_miss_count, write_back_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sacl_lookup.sv */
// Set lookup: tag compare, victim choice and LRU/valid/dirty update of one set row.
// Purely combinational; depends on sacl_pkg.
`default_nettype none

module sacl_lookup #(
   parameter int NUM_WAYS = 8
) (
   input  wire logic                                                command,
   input  wire logic [sacl_pkg::TAG_W-1:0]                          tag,
   input  wire logic [NUM_WAYS-1:0][sacl_pkg::TAG_W-1:0]            tags_i,
   input  wire logic [NUM_WAYS-1:0]                                 valid_i,
   input  wire logic [NUM_WAYS-1:0]                                 dirty_i,
   input  wire logic [NUM_WAYS-1:0][((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] rank_i,
   output      logic [NUM_WAYS-1:0][sacl_pkg::TAG_W-1:0]            tags_o,
   output      logic [NUM_WAYS-1:0]                                 valid_o,
   output      logic [NUM_WAYS-1:0]                                 dirty_o,
   output      logic [NUM_WAYS-1:0][((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] rank_o,
   output      sacl_pkg::lookup_result_type                         result
);

   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   logic             hit;
   logic [WAY_W-1:0] hit_way;
   logic             free_found;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] lru_way;
   logic [WAY_W-1:0] way;
   logic [WAY_W-1:0] old_rank;
   logic             is_write;

   always_comb begin
      is_write   = (command == sacl_pkg::CMD_WRITE);
      hit        = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      lru_way    = '0;
      // descending scans leave the lowest matching way
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (valid_i[w] && (tags_i[w] == tag)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!valid_i[w]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (rank_i[w] == WAY_W'(NUM_WAYS - 1)) begin
            lru_way = WAY_W'(w);
         end
      end

      if (hit) begin
         way = hit_way;
      end else if (free_found) begin
         way = free_way;
      end else begin
         way = lru_way;
      end
      old_rank = rank_i[way];

      tags_o  = tags_i;
      valid_o = valid_i;
      dirty_o = dirty_i;
      for (int j = 0; j < NUM_WAYS; j++) begin
         rank_o[j] = (rank_i[j] < old_rank) ? rank_i[j] + WAY_W'(1) : rank_i[j];
      end
      rank_o[way]  = '0;
      valid_o[way] = 1'b1;
      if (hit) begin
         dirty_o[way] = dirty_i[way] | is_write;
      end else begin
         tags_o[way]  = tag;
         dirty_o[way] = is_write;
      end

      result.hit        = hit;
      result.write_back = !hit && !free_found && dirty_i[lru_way];
      result.way        = sacl_pkg::WAY_MAX_W'(way);
   end

endmodule

`default_nettype wire

/* hw/rtl/set_assoc_cache_lru_writeback.sv */
// Top level of the set-associative write-back, write-allocate cache tag store.
// Depends on sacl_pkg, sacl_req_if, sacl_rsp_if and sacl_lookup.
//
//   port      direction  word / use
//   req_bus   in         command, address
//   rsp_bus   out        hit, write_back, way_used, five 32-bit counters
//   csr_*     in/out     APB registers: index_bits at 0x0, offset_bits at 0x4
//
// One access per cycle unless the response stalls; stage 1 feeds the response register.
// The set row is read from the tag memories at accept and written back when the
// response register loads; an access to the set updated in that same cycle uses a bypass.
// Reset (synchronous) clears counters, handshake state and one init bit per set;
// an uninitialized set reads as empty with ranks in way order. A stalled response
// holds the update stage; requests are taken while the stage is free or draining.
`default_nettype none

module set_assoc_cache_lru_writeback #(
   parameter int NUM_WAYS = 8,
   parameter int MAX_SETS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sacl_req_if.sink                                req_bus,
   sacl_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [sacl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [sacl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [sacl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                               csr_pready
);

   localparam int CLOG_SETS = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 0;
   localparam int MAXB_RAW  = ((1 << CLOG_SETS) == MAX_SETS) ? CLOG_SETS : CLOG_SETS - 1;
   localparam int MAXB      = (MAXB_RAW > 12) ? 12 : MAXB_RAW;
   localparam int SETS      = 1 << MAXB;
   localparam int IDX_W     = (MAXB > 0) ? MAXB : 1;
   localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int TAG_W     = sacl_pkg::TAG_W;
   localparam int CNT_W     = sacl_pkg::COUNT_W;

   // configuration
   logic [sacl_pkg::INDEX_CFG_W-1:0]  index_bits_ff;
   logic [sacl_pkg::OFFSET_CFG_W-1:0] offset_bits_ff;
   logic                              csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff  <= sacl_pkg::INDEX_BITS_RESET;
         offset_bits_ff <= sacl_pkg::OFFSET_BITS_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[sacl_pkg::CSR_SEL_BIT])
            sacl_pkg::REG_INDEX_BITS: begin
               index_bits_ff <= csr_pwdata[sacl_pkg::INDEX_CFG_W-1:0];
            end
            sacl_pkg::REG_OFFSET_BITS: begin
               offset_bits_ff <= csr_pwdata[sacl_pkg::OFFSET_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[sacl_pkg::CSR_SEL_BIT])
         sacl_pkg::REG_INDEX_BITS:  csr_prdata = sacl_pkg::CSR_DATA_W'(index_bits_ff);
         sacl_pkg::REG_OFFSET_BITS: csr_prdata = sacl_pkg::CSR_DATA_W'(offset_bits_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // address split
   logic [3:0]       eff_index_bits;
   logic [4:0]       tag_shift;
   logic [31:0]      set_mask;
   logic [31:0]      set_full;
   logic [IDX_W-1:0] req_set;
   logic [TAG_W-1:0] req_tag;

   always_comb begin
      eff_index_bits = (4'(index_bits_ff) > 4'(MAXB)) ? 4'(MAXB) : 4'(index_bits_ff);
      set_mask       = (32'd1 << eff_index_bits) - 32'd1;
      set_full       = (req_bus.address >> offset_bits_ff) & set_mask;
      req_set        = set_full[IDX_W-1:0];
      tag_shift      = 5'(offset_bits_ff) + 5'(eff_index_bits);
      req_tag        = req_bus.address >> tag_shift;
   end

   // pipeline control
   logic req_accept;
   logic s1_advance;
   logic s1_valid_ff;
   logic rsp_valid_ff;

   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stage 1 request word
   logic             s1_command_ff;
   logic [IDX_W-1:0] s1_set_ff;
   logic [TAG_W-1:0] s1_tag_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff <= req_bus.command;
         s1_set_ff     <= req_set;
         s1_tag_ff     <= req_tag;
      end
   end

   // set memories
   logic [NUM_WAYS-1:0][TAG_W-1:0] tag_mem   [SETS];
   logic [NUM_WAYS-1:0]            valid_mem [SETS];
   logic [NUM_WAYS-1:0]            dirty_mem [SETS];
   logic [NUM_WAYS-1:0][WAY_W-1:0] rank_mem  [SETS];

   logic [NUM_WAYS-1:0][TAG_W-1:0] rd_tags_ff;
   logic [NUM_WAYS-1:0]            rd_valid_ff;
   logic [NUM_WAYS-1:0]            rd_dirty_ff;
   logic [NUM_WAYS-1:0][WAY_W-1:0] rd_rank_ff;

   logic [NUM_WAYS-1:0][TAG_W-1:0] new_tags;
   logic [NUM_WAYS-1:0]            new_valid;
   logic [NUM_WAYS-1:0]            new_dirty;
   logic [NUM_WAYS-1:0][WAY_W-1:0] new_rank;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         tag_mem[s1_set_ff]   <= new_tags;
         valid_mem[s1_set_ff] <= new_valid;
         dirty_mem[s1_set_ff] <= new_dirty;
         rank_mem[s1_set_ff]  <= new_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_tags_ff  <= tag_mem[req_set];
         rd_valid_ff <= valid_mem[req_set];
         rd_dirty_ff <= dirty_mem[req_set];
         rd_rank_ff  <= rank_mem[req_set];
      end
   end

   // per-set init bits and same-set bypass
   logic [SETS-1:0]                row_init_ff;
   logic                           s1_init_ff;
   logic                           byp_ff;
   logic [NUM_WAYS-1:0][TAG_W-1:0] byp_tags_ff;
   logic [NUM_WAYS-1:0]            byp_valid_ff;
   logic [NUM_WAYS-1:0]            byp_dirty_ff;
   logic [NUM_WAYS-1:0][WAY_W-1:0] byp_rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff <= '0;
         s1_init_ff  <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         if (s1_advance) begin
            row_init_ff[s1_set_ff] <= 1'b1;
         end
         if (req_accept) begin
            s1_init_ff <= row_init_ff[req_set];
            byp_ff     <= s1_advance && (s1_set_ff == req_set);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byp_tags_ff  <= new_tags;
         byp_valid_ff <= new_valid;
         byp_dirty_ff <= new_dirty;
         byp_rank_ff  <= new_rank;
      end
   end

   logic [NUM_WAYS-1:0][TAG_W-1:0] cur_tags;
   logic [NUM_WAYS-1:0]            cur_valid;
   logic [NUM_WAYS-1:0]            cur_dirty;
   logic [NUM_WAYS-1:0][WAY_W-1:0] cur_rank;

   always_comb begin
      priority if (byp_ff) begin
         cur_tags  = byp_tags_ff;
         cur_valid = byp_valid_ff;
         cur_dirty = byp_dirty_ff;
         cur_rank  = byp_rank_ff;
      end else if (s1_init_ff) begin
         cur_tags  = rd_tags_ff;
         cur_valid = rd_valid_ff;
         cur_dirty = rd_dirty_ff;
         cur_rank  = rd_rank_ff;
      end else begin
         cur_tags  = rd_tags_ff;
         cur_valid = '0;
         cur_dirty = '0;
         for (int w = 0; w < NUM_WAYS; w++) begin
            cur_rank[w] = WAY_W'(w);
         end
      end
   end

   sacl_pkg::lookup_result_type lookup;

   sacl_lookup #(
      .NUM_WAYS (NUM_WAYS)
   ) u_lookup (
      .command (s1_command_ff),
      .tag     (s1_tag_ff),
      .tags_i  (cur_tags),
      .valid_i (cur_valid),
      .dirty_i (cur_dirty),
      .rank_i  (cur_rank),
      .tags_o  (new_tags),
      .valid_o (new_valid),
      .dirty_o (new_dirty),
      .rank_o  (new_rank),
      .result  (lookup)
   );

   // counters and response register
   logic             s1_write;
   logic [CNT_W-1:0] read_hits_ff,  read_hits_in;
   logic [CNT_W-1:0] write_hit_ff,  write_hit_in;
   logic [CNT_W-1:0] read_miss_ff,  read_miss_in;
   logic [CNT_W-1:0] write_miss_ff, write_miss_in;
   logic [CNT_W-1:0] write_back_ff, write_back_in;

   always_comb begin
      s1_write      = (s1_command_ff == sacl_pkg::CMD_WRITE);
      read_hits_in  = read_hits_ff  + CNT_W'(lookup.hit && !s1_write);
      write_hit_in  = write_hit_ff  + CNT_W'(lookup.hit && s1_write);
      read_miss_in  = read_miss_ff  + CNT_W'(!lookup.hit && !s1_write);
      write_miss_in = write_miss_ff + CNT_W'(!lookup.hit && s1_write);
      write_back_in = write_back_ff + CNT_W'(lookup.write_back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_hits_ff  <= '0;
         write_hit_ff  <= '0;
         read_miss_ff  <= '0;
         write_miss_ff <= '0;
         write_back_ff <= '0;
      end else if (s1_advance) begin
         read_hits_ff  <= read_hits_in;
         write_hit_ff  <= write_hit_in;
         read_miss_ff  <= read_miss_in;
         write_miss_ff <= write_miss_in;
         write_back_ff <= write_back_in;
      end
   end

   logic                           rsp_hit_ff;
   logic                           rsp_write_back_ff;
   logic [sacl_pkg::WAY_OUT_W-1:0] rsp_way_ff;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_hit_ff        <= lookup.hit;
         rsp_write_back_ff <= lookup.write_back;
         rsp_way_ff        <= lookup.way[sacl_pkg::WAY_OUT_W-1:0];
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.hit              = rsp_hit_ff;
   assign rsp_bus.write_back       = rsp_write_back_ff;
   assign rsp_bus.way_used         = rsp_way_ff;
   assign rsp_bus.read_hit_count   = read_hits_ff;
   assign rsp_bus.write_hit_count  = write_hit_ff;
   assign rsp_bus.read_miss_count  = read_miss_ff;
   assign rsp_bus.write_miss_count = write_miss_ff;
   assign rsp_bus.write_back_count = write_back_ff;

endmodule

`default_nettype wire

/* hw/rtl/sacl_checker.sv */
// Port-level checks on the cache response stream, bound to the top level.
// Depends on sacl_pkg and set_assoc_cache_lru_writeback.
`default_nettype none

module sacl_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           hit,
   input wire logic                           write_back,
   input wire logic [sacl_pkg::WAY_OUT_W-1:0] way_used,
   input wire logic [sacl_pkg::COUNT_W-1:0]   read_hit_count,
   input wire logic [sacl_pkg::COUNT_W-1:0]   write_hit_count,
   input wire logic [sacl_pkg::COUNT_W-1:0]   read_miss_count,
   input wire logic [sacl_pkg::COUNT_W-1:0]   write_miss_count,
   input wire logic [sacl_pkg::COUNT_W-1:0]   write_back_count
);

   logic                         rsp_take;
   logic [sacl_pkg::COUNT_W-1:0] total;
   logic [sacl_pkg::COUNT_W-1:0] last_total_ff;
   logic [sacl_pkg::COUNT_W-1:0] last_wb_ff;

   assign rsp_take = rsp_valid && rsp_ready;
   assign total    = read_hit_count + write_hit_count + read_miss_count + write_miss_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff <= '0;
         last_wb_ff    <= '0;
      end else if (rsp_take) begin
         last_total_ff <= total;
         last_wb_ff    <= write_back_count;
      end
   end

   a_no_word_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(write_back)
                                  && $stable(way_used) && $stable(total))
      else $error("stalled response word changed");

   a_one_access_per_word: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> total == last_total_ff + sacl_pkg::COUNT_W'(1))
      else $error("access counters did not advance by one");

   a_write_back_count: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> write_back_count == last_wb_ff + sacl_pkg::COUNT_W'(write_back)
                   && !(hit && write_back))
      else $error("write-back count does not follow write_back flag");

endmodule

bind set_assoc_cache_lru_writeback sacl_checker u_sacl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .hit              (rsp_bus.hit),
   .write_back       (rsp_bus.write_back),
   .way_used         (rsp_bus.way_used),
   .read_hit_count   (rsp_bus.read_hit_count),
   .write_hit_count  (rsp_bus.write_hit_count),
   .read_miss_count  (rsp_bus.read_miss_count),
   .write_miss_count (rsp_bus.write_miss_count),
   .write_back_count (rsp_bus.write_back_count)
);

`default_nettype wire

/* tb/tb_set_assoc_cache_lru_writeback.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative LRU write-back cache tag store.
// Drives random and directed accesses, predicts every response word and compares it.
// Depends on sacl_pkg, sacl_req_if, sacl_rsp_if and set_assoc_cache_lru_writeback.

module tb_set_assoc_cache_lru_writeback;

   localparam int NUM_WAYS   = 8;
   localparam int MAX_SETS   = 64;
   localparam int SET_BITS   = $clog2(MAX_SETS);
   localparam int LONG_HOLD  = 60;
   localparam int PHASE_LEN  = 240;
   localparam int NUM_PHASES = 6;

   typedef struct {
      logic                        cmd;
      logic [sacl_pkg::ADDR_W-1:0] addr;
   } access_type;

   typedef struct {
      logic                           hit;
      logic                           write_back;
      logic [sacl_pkg::WAY_OUT_W-1:0] way_used;
      logic [sacl_pkg::COUNT_W-1:0]   read_hits;
      logic [sacl_pkg::COUNT_W-1:0]   wr_hit_cnt;
      logic [sacl_pkg::COUNT_W-1:0]   read_misses;
      logic [sacl_pkg::COUNT_W-1:0]   wr_miss_cnt;
      logic [sacl_pkg::COUNT_W-1:0]   evict_cnt;
   } cache_outcome_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [sacl_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [sacl_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [sacl_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   sacl_req_if req_bus ();
   sacl_rsp_if rsp_bus ();

   set_assoc_cache_lru_writeback #(
      .NUM_WAYS(NUM_WAYS),
      .MAX_SETS(MAX_SETS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // predictor state
   logic [sacl_pkg::TAG_W-1:0] tag_mem  [MAX_SETS][NUM_WAYS];
   bit               line_vld [MAX_SETS][NUM_WAYS];
   bit               line_drt [MAX_SETS][NUM_WAYS];
   int               lru_age  [MAX_SETS][NUM_WAYS];
   logic [sacl_pkg::COUNT_W-1:0] n_read_hits, n_wr_hits, n_read_misses, n_wr_misses, n_evicts;
   int cfg_index_bits;
   int cfg_offset_bits;

   access_type        pending_accesses[$];
   cache_outcome_type expected_outcomes[$];
   access_type        next_access;
   cache_outcome_type want;

   int  words_queued;
   int  words_taken;
   int  words_checked;
   int  errors;
   int  send_gap;
   int  recv_gap;
   int  hold_left;
   int  hold_requests;
   int  holds_done;
   int  settings_used;
   bit  idle_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("set_assoc_cache_lru_writeback: mismatch");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int eff_index_bits();
      return (cfg_index_bits > SET_BITS) ? SET_BITS : cfg_index_bits;
   endfunction

   function automatic cache_outcome_type predict_access(logic cmd,
                                                        logic [sacl_pkg::ADDR_W-1:0] addr);
      cache_outcome_type o;
      int ib, s, w, way, old;
      logic [sacl_pkg::TAG_W-1:0] tag;
      bit hit, found, wb;
      ib    = eff_index_bits();
      s     = int'((addr >> cfg_offset_bits) & ((32'd1 << ib) - 1));
      tag   = addr >> (cfg_offset_bits + ib);
      hit   = 1'b0;
      found = 1'b0;
      wb    = 1'b0;
      way   = 0;
      for (w = 0; w < NUM_WAYS; w++) begin
         if (!hit && line_vld[s][w] && tag_mem[s][w] == tag) begin
            hit = 1'b1;
            way = w;
         end
      end
      if (hit) begin
         if (cmd == sacl_pkg::CMD_WRITE) begin
            line_drt[s][way] = 1'b1;
            n_wr_hits++;
         end else begin
            n_read_hits++;
         end
      end else begin
         if (cmd == sacl_pkg::CMD_WRITE) n_wr_misses++;
         else n_read_misses++;
         for (w = 0; w < NUM_WAYS; w++) begin
            if (!found && !line_vld[s][w]) begin
               way   = w;
               found = 1'b1;
            end
         end
         if (!found) begin
            for (w = 0; w < NUM_WAYS; w++)
               if (lru_age[s][w] == NUM_WAYS - 1) way = w;
            if (line_drt[s][way]) begin
               wb = 1'b1;
               n_evicts++;
            end
         end
         tag_mem[s][way]  = tag;
         line_vld[s][way] = 1'b1;
         line_drt[s][way] = (cmd == sacl_pkg::CMD_WRITE);
      end
      old = lru_age[s][way];
      for (w = 0; w < NUM_WAYS; w++)
         if (lru_age[s][w] < old) lru_age[s][w]++;
      lru_age[s][way] = 0;

      o.hit         = hit;
      o.write_back  = wb;
      o.way_used    = way[sacl_pkg::WAY_OUT_W-1:0];
      o.read_hits   = n_read_hits;
      o.wr_hit_cnt  = n_wr_hits;
      o.read_misses = n_read_misses;
      o.wr_miss_cnt = n_wr_misses;
      o.evict_cnt   = n_evicts;
      return o;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t %s: expected %0h, got %0h", $time, name, exp_v, got_v);
         errors++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_outcomes.push_back(predict_access(req_bus.command, req_bus.address));
            words_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap      <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               next_access      = pending_accesses.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.command <= next_access.cmd;
               req_bus.address <= next_access.addr;
               send_gap        <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with random gaps and the occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         recv_gap      <= 0;
         holds_done    <= 0;
      end else if (holds_done != hold_requests) begin
         holds_done    <= holds_done + 1;
         hold_left     <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap      <= recv_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t unexpected response word: expected none, got hit=%0b way=%0d",
                     $time, rsp_bus.hit, rsp_bus.way_used);
            errors++;
         end else begin
            want = expected_outcomes.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_bus.hit));
            check_field("write_back", 32'(want.write_back), 32'(rsp_bus.write_back));
            check_field("way_used", 32'(want.way_used), 32'(rsp_bus.way_used));
            check_field("read_hit_count", want.read_hits, rsp_bus.read_hit_count);
            check_field("write_hit_count", want.wr_hit_cnt, rsp_bus.write_hit_count);
            check_field("read_miss_count", want.read_misses, rsp_bus.read_miss_count);
            check_field("write_miss_count", want.wr_miss_cnt, rsp_bus.write_miss_count);
            check_field("write_back_count", want.evict_cnt, rsp_bus.write_back_count);
            words_checked++;
         end
      end
   end

   task automatic queue_access(logic cmd, logic [sacl_pkg::ADDR_W-1:0] addr);
      access_type a;
      a.cmd  = cmd;
      a.addr = addr;
      pending_accesses.push_back(a);
      words_queued++;
   endtask

   function automatic logic [sacl_pkg::ADDR_W-1:0] make_addr(logic [sacl_pkg::TAG_W-1:0] tag,
                                                            int set_i);
      logic [sacl_pkg::ADDR_W-1:0] a;
      int ib, off;
      ib  = eff_index_bits();
      off = cfg_offset_bits;
      a   = (tag << (off + ib)) | (32'(set_i) << off);
      if (off > 0) a = a | ($urandom & ((32'd1 << off) - 1));
      return a;
   endfunction

   task automatic wait_drained();
      while (words_taken != words_queued || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, int value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= sacl_pkg::CSR_ADDR_W'(reg_sel) << sacl_pkg::CSR_SEL_BIT;
      csr_pwdata  <= sacl_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == sacl_pkg::REG_INDEX_BITS) cfg_index_bits = value & 7;
      else cfg_offset_bits = value & 15;
   endtask

   task automatic random_phase(int count);
      logic [sacl_pkg::TAG_W-1:0] tag_base;
      int hot[3];
      int k, r, nsets;
      logic cmd;
      logic [sacl_pkg::ADDR_W-1:0] a;
      nsets    = 1 << eff_index_bits();
      tag_base = $urandom;
      for (k = 0; k < 3; k++) hot[k] = $urandom_range(0, nsets - 1);
      for (k = 0; k < count; k++) begin
         r   = $urandom_range(0, 99);
         cmd = ($urandom_range(0, 99) < 45) ? sacl_pkg::CMD_WRITE : sacl_pkg::CMD_READ;
         if (r < 70)
            a = make_addr(tag_base + $urandom_range(0, 11), hot[$urandom_range(0, 2)]);
         else if (r < 85)
            a = make_addr(tag_base + $urandom_range(0, 11), $urandom_range(0, nsets - 1));
         else
            a = $urandom;
         queue_access(cmd, a);
      end
   endtask

   int phase_index_bits  [NUM_PHASES] = '{0, 7, 6, 2, 3, 1};
   int phase_offset_bits [NUM_PHASES] = '{0, 15, 12, 5, 1, 9};

   initial begin
      int p, t, n;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_bus.valid   = 1'b0;
      req_bus.command = sacl_pkg::CMD_READ;
      req_bus.address = '0;
      rsp_bus.ready   = 1'b0;
      idle_on         = 1'b1;
      cfg_index_bits  = int'(sacl_pkg::INDEX_BITS_RESET);
      cfg_offset_bits = int'(sacl_pkg::OFFSET_BITS_RESET);
      for (int s = 0; s < MAX_SETS; s++)
         for (int w = 0; w < NUM_WAYS; w++) begin
            tag_mem[s][w]  = '0;
            line_vld[s][w] = 1'b0;
            line_drt[s][w] = 1'b0;
            lru_age[s][w]  = w;
         end
      n_read_hits   = '0;
      n_wr_hits     = '0;
      n_read_misses = '0;
      n_wr_misses   = '0;
      n_evicts      = '0;
      settings_used = 1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill one set, then evict dirty lines in LRU order
      queue_access(sacl_pkg::CMD_READ, 32'h0000_0000);
      queue_access(sacl_pkg::CMD_WRITE, 32'h0000_0007);
      queue_access(sacl_pkg::CMD_WRITE, 32'hFFFF_FFFF);
      queue_access(sacl_pkg::CMD_READ, 32'hFFFF_FFFF);
      for (t = 1; t < NUM_WAYS; t++) queue_access(sacl_pkg::CMD_WRITE, make_addr(t, 0));
      queue_access(sacl_pkg::CMD_READ, make_addr(8, 0));
      queue_access(sacl_pkg::CMD_READ, make_addr(9, 0));
      queue_access(sacl_pkg::CMD_WRITE, make_addr(1, 0));
      queue_access(sacl_pkg::CMD_READ, make_addr(8, 0));
      queue_access(sacl_pkg::CMD_READ, make_addr(10, 0));
      queue_access(sacl_pkg::CMD_READ, 32'h8000_0000);
      queue_access(sacl_pkg::CMD_WRITE, 32'h7FFF_FFF8);
      wait_drained();

      for (p = 0; p < NUM_PHASES; p++) begin
         csr_write(sacl_pkg::REG_INDEX_BITS, phase_index_bits[p]);
         csr_write(sacl_pkg::REG_OFFSET_BITS, phase_offset_bits[p]);
         settings_used++;
         idle_on = (p != 2);
         random_phase(PHASE_LEN);
         if (p == 0 || p == 3) begin
            repeat (2) @(posedge clock);
            hold_requests++;
         end
         wait_drained();
      end

      n = 0;
      while (n < 5000 && (words_taken != words_queued || expected_outcomes.size() != 0)) begin
         @(posedge clock);
         n++;
      end
      repeat (10) @(posedge clock);
      if (expected_outcomes.size() != 0 || words_taken != words_queued) begin
         $display("%0t responses missing: expected %0d more, got none", $time,
                  expected_outcomes.size() + words_queued - words_taken);
         errors++;
      end

      $display("%0d accesses checked under %0d index/offset settings", words_checked,
               settings_used);
      $display("hits %0d, misses %0d, dirty evictions %0d, errors %0d",
               n_read_hits + n_wr_hits, n_read_misses + n_wr_misses, n_evicts,
               errors);
      if (errors == 0) begin
         $display("set_assoc_cache_lru_writeback: match");
      end else begin
         $display("set_assoc_cache_lru_writeback: mismatch");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_req_if.sv
hw/rtl/sacl_rsp_if.sv
hw/rtl/sacl_lookup.sv
hw/rtl/set_assoc_cache_lru_writeback.sv
hw/rtl/sacl_checker.sv
tb/tb_set_assoc_cache_lru_writeback.sv
